// File: src/sndsyn_pkg.sv
// Shared types and constants for the spiking neuron with delayed synapses.
package sndsyn_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_RECV  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam int unsigned PADDR_W = 5;

  localparam logic [2:0] REG_V_THRESHOLD      = 3'd0;
  localparam logic [2:0] REG_LEAK_STEP        = 3'd1;
  localparam logic [2:0] REG_REFRACTORY_TICKS = 3'd2;
  localparam logic [2:0] REG_IS_GENERATOR     = 3'd3;
  localparam logic [2:0] REG_ACTIVE_SYNAPSES  = 3'd4;

  localparam logic [15:0] V_RESET    = 16'd20000;
  localparam logic [15:0] LEAK_LOW   = 16'd27500;
  localparam logic [15:0] LEAK_HIGH  = 16'd28500;
  localparam logic [15:0] CLAMP_HIGH = 16'd50000;
  localparam logic [15:0] V_REST     = 16'd28000;

  typedef logic [8:0] timer_t;
  localparam timer_t TIMER_IDLE = 9'h1FF;

  typedef struct packed {
    logic inject;
    logic shift;
    logic clear;
    logic spike;
  } cell_ctl_t;

endpackage

// File: src/sndsyn_cell.sv
// One synapse cell: entry storage, delay timer and walk token.
module sndsyn_cell #(
  parameter int INDEX       = 0,
  parameter int CNT_W       = 4,
  parameter int TARGET_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sndsyn_pkg::cell_ctl_t     ctl,
  input  logic [CNT_W-1:0]          n_act,
  input  logic                      wr_en,
  input  logic [TARGET_BITS-1:0]    wr_target,
  input  logic signed [15:0]        wr_weight,
  input  logic [7:0]                wr_delay,
  input  logic                      tok_in,
  output logic                      tok_out,
  input  logic                      later_in,
  output logic                      later_out,
  output logic                      sel,
  output logic                      sel_last,
  output logic [TARGET_BITS-1:0]    sel_target,
  output logic signed [15:0]        sel_weight
);
  import sndsyn_pkg::*;

  logic [TARGET_BITS-1:0] target_r;
  logic signed [15:0]     weight_r;
  logic [7:0]             delay_r;
  timer_t                 timer_r, timer_nxt, eff;
  logic                   tok_r, tok_nxt;
  logic                   in_range, deliver;

  always_comb begin
    in_range = CNT_W'(INDEX) < n_act;
    eff      = (ctl.spike && timer_r == TIMER_IDLE) ? {1'b0, delay_r} : timer_r;
    deliver  = in_range && eff == '0;
    if (ctl.clear) begin
      tok_nxt = 1'b0;
    end else if (ctl.shift) begin
      tok_nxt = tok_in;
    end else begin
      tok_nxt = tok_r;
    end
    timer_nxt = timer_r;
    if (tok_r && ctl.shift && in_range) begin
      if (deliver) begin
        timer_nxt = TIMER_IDLE;
      end else if (eff != TIMER_IDLE) begin
        timer_nxt = eff - timer_t'(1);
      end
    end
  end

  assign tok_out    = tok_r;
  assign later_out  = later_in | deliver;
  assign sel        = tok_r & deliver;
  assign sel_last   = sel & ~later_in;
  assign sel_target = sel ? target_r : '0;
  assign sel_weight = sel ? weight_r : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      target_r <= wr_target;
      weight_r <= wr_weight;
      delay_r  <= wr_delay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r   <= 1'b0;
      timer_r <= TIMER_IDLE;
    end else begin
      tok_r   <= tok_nxt;
      timer_r <= timer_nxt;
    end
  end

endmodule

// File: src/spiking_neuron_with_delay_synapses.sv
// Top level: leaky integrate-and-fire neuron with a chain of delayed synapse cells.
// Each input transaction yields one status result (deliver_valid 0) followed, for a tick,
// by one delivery result per synapse whose timer expires, in entry order; last marks the
// final result. An accepted transaction enters the status state, which loads the status
// result into the output register once that register is free; receive, write and unknown
// commands then return to idle and accept the next transaction. For a tick with n =
// min(active_synapses, SYNAPSES) nonzero, a token walks the synapse cells one per cycle,
// arming, counting down and delivering, and stalls while a delivery waits to load into
// the held output register. Configuration registers sit at byte addresses 4*i; the user
// must write them only while no transaction is in progress; the block does not check it.
module spiking_neuron_with_delay_synapses #(
  parameter int SYNAPSES    = 8,
  parameter int TARGET_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_command,
  input  logic signed [15:0]              in_input_weight,
  input  logic [2:0]                      in_synapse_index,
  input  logic [TARGET_BITS-1:0]          in_target_index,
  input  logic signed [15:0]              in_synapse_weight,
  input  logic [7:0]                      in_synapse_delay,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_spike,
  output logic [15:0]                     out_membrane,
  output logic                            out_deliver_valid,
  output logic [TARGET_BITS-1:0]          out_deliver_target,
  output logic signed [15:0]              out_deliver_weight,
  output logic                            out_last,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sndsyn_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import sndsyn_pkg::*;

  localparam int CNT_W = ($clog2(SYNAPSES + 1) > 4) ? $clog2(SYNAPSES + 1) : 4;
  localparam int IDX_W = (SYNAPSES > 1) ? $clog2(SYNAPSES) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_STATUS = 2'd1;
  localparam logic [1:0] ST_WALK   = 2'd2;

  logic [15:0] cfg_thr_r;
  logic [11:0] cfg_leak_r;
  logic [15:0] cfg_refr_r;
  logic        cfg_gen_r;
  logic [3:0]  cfg_active_r;
  logic        cfg_wr;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]      membrane_r;
  logic [15:0]      refr_r;
  logic             spk_r;
  logic             is_tick_r;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_spike_r;
  logic [15:0]            out_membrane_r;
  logic                   out_dv_r;
  logic [TARGET_BITS-1:0] out_target_r;
  logic signed [15:0]     out_weight_r;
  logic                   out_last_r;

  logic             in_fire, wr_fire, slot_free;
  logic             load_status, load_del;
  cell_ctl_t        ctl;
  logic [CNT_W-1:0] act_ext, n_act;

  logic        fire, spk_tick;
  logic [15:0] v_fire, v_up, v_tick, rc_fire, rc_tick, leak_ext;
  logic [16:0] v_sum;
  logic signed [17:0] r_sum;
  logic [15:0] v_recv;

  logic [SYNAPSES:0]      tok_chain;
  logic [SYNAPSES:0]      later_chain;
  logic [SYNAPSES-1:0]    wr_en;
  logic [SYNAPSES-1:0]    sel_v;
  logic [SYNAPSES-1:0]    sel_last_v;
  logic [TARGET_BITS-1:0] sel_tgt [SYNAPSES];
  logic signed [15:0]     sel_wt  [SYNAPSES];
  logic                   del_any, del_last, any_pend;
  logic [TARGET_BITS-1:0] del_target;
  logic [15:0]            del_weight;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_thr_r    <= LEAK_LOW;
      cfg_leak_r   <= 12'd100;
      cfg_refr_r   <= '0;
      cfg_gen_r    <= 1'b0;
      cfg_active_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_V_THRESHOLD:      cfg_thr_r    <= pwdata[15:0];
        REG_LEAK_STEP:        cfg_leak_r   <= pwdata[11:0];
        REG_REFRACTORY_TICKS: cfg_refr_r   <= pwdata[15:0];
        REG_IS_GENERATOR:     cfg_gen_r    <= pwdata[0];
        REG_ACTIVE_SYNAPSES:  cfg_active_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_V_THRESHOLD:      prdata = {16'd0, cfg_thr_r};
      REG_LEAK_STEP:        prdata = {20'd0, cfg_leak_r};
      REG_REFRACTORY_TICKS: prdata = {16'd0, cfg_refr_r};
      REG_IS_GENERATOR:     prdata = {31'd0, cfg_gen_r};
      REG_ACTIVE_SYNAPSES:  prdata = {28'd0, cfg_active_r};
      default:              prdata = '0;
    endcase
  end

  always_comb begin
    act_ext = CNT_W'(cfg_active_r);
    n_act   = (act_ext > CNT_W'(SYNAPSES)) ? CNT_W'(SYNAPSES) : act_ext;
  end

  // Neuron update for a tick and a receive.
  always_comb begin
    leak_ext = {4'd0, cfg_leak_r};
    fire     = (membrane_r >= cfg_thr_r) && (refr_r == '0);
    spk_tick = cfg_gen_r | fire;
    v_fire   = fire ? V_RESET : membrane_r;
    rc_fire  = fire ? cfg_refr_r : refr_r;
    v_sum    = {1'b0, v_fire} + {1'b0, leak_ext};
    v_up     = (v_fire < LEAK_LOW) ? (v_sum[16] ? 16'hFFFF : v_sum[15:0]) : v_fire;
    if (v_up > LEAK_HIGH) begin
      v_tick = (v_up > leak_ext) ? v_up - leak_ext : '0;
    end else begin
      v_tick = v_up;
    end
    rc_tick = (rc_fire != '0) ? rc_fire - 16'd1 : '0;
    r_sum   = $signed({2'b00, membrane_r}) + $signed({{2{in_input_weight[15]}}, in_input_weight});
    if (r_sum < $signed({2'b00, V_RESET})) begin
      v_recv = V_RESET;
    end else if (r_sum > $signed({2'b00, CLAMP_HIGH})) begin
      v_recv = CLAMP_HIGH;
    end else begin
      v_recv = r_sum[15:0];
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign wr_fire   = in_fire && (in_command == CMD_WRITE);
  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      membrane_r <= V_REST;
      refr_r     <= '0;
      spk_r      <= 1'b0;
      is_tick_r  <= 1'b0;
    end else if (in_fire) begin
      unique case (in_command)
        CMD_TICK: begin
          membrane_r <= v_tick;
          refr_r     <= rc_tick;
          spk_r      <= spk_tick;
          is_tick_r  <= 1'b1;
        end
        CMD_RECV: begin
          membrane_r <= v_recv;
          spk_r      <= 1'b0;
          is_tick_r  <= 1'b0;
        end
        default: begin
          spk_r     <= 1'b0;
          is_tick_r <= 1'b0;
        end
      endcase
    end
  end

  assign tok_chain[0]          = ctl.inject;
  assign later_chain[SYNAPSES] = 1'b0;
  assign any_pend              = later_chain[0];

  for (genvar i = 0; i < SYNAPSES; i++) begin : g_cell
    assign wr_en[i] = wr_fire && (int'(in_synapse_index) == i);

    sndsyn_cell #(
      .INDEX       (i),
      .CNT_W       (CNT_W),
      .TARGET_BITS (TARGET_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .n_act      (n_act),
      .wr_en      (wr_en[i]),
      .wr_target  (in_target_index),
      .wr_weight  (in_synapse_weight),
      .wr_delay   (in_synapse_delay),
      .tok_in     (tok_chain[i]),
      .tok_out    (tok_chain[i+1]),
      .later_in   (later_chain[i+1]),
      .later_out  (later_chain[i]),
      .sel        (sel_v[i]),
      .sel_last   (sel_last_v[i]),
      .sel_target (sel_tgt[i]),
      .sel_weight (sel_wt[i])
    );
  end

  always_comb begin
    del_any    = |sel_v;
    del_last   = |sel_last_v;
    del_target = '0;
    del_weight = '0;
    for (int i = 0; i < SYNAPSES; i++) begin
      del_target = del_target | sel_tgt[i];
      del_weight = del_weight | sel_wt[i];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    load_status = 1'b0;
    load_del    = 1'b0;
    ctl.inject  = 1'b0;
    ctl.shift   = 1'b0;
    ctl.clear   = (state_r == ST_IDLE);
    ctl.spike   = spk_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_STATUS;
        end
      end
      ST_STATUS: begin
        if (slot_free) begin
          load_status = 1'b1;
          if (is_tick_r && n_act != '0) begin
            ctl.inject = 1'b1;
            ctl.shift  = 1'b1;
            idx_nxt    = '0;
            state_nxt  = ST_WALK;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_WALK: begin
        if (!del_any || slot_free) begin
          ctl.shift = 1'b1;
          load_del  = del_any;
          if (CNT_W'(idx_r) == n_act - CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    if (load_status || load_del) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_status) begin
      out_spike_r    <= spk_r;
      out_membrane_r <= membrane_r;
      out_dv_r       <= 1'b0;
      out_target_r   <= '0;
      out_weight_r   <= '0;
      out_last_r     <= !(is_tick_r && any_pend);
    end else if (load_del) begin
      out_spike_r    <= spk_r;
      out_membrane_r <= membrane_r;
      out_dv_r       <= 1'b1;
      out_target_r   <= del_target;
      out_weight_r   <= del_weight;
      out_last_r     <= del_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_spike          = out_spike_r;
  assign out_membrane       = out_membrane_r;
  assign out_deliver_valid  = out_dv_r;
  assign out_deliver_target = out_target_r;
  assign out_deliver_weight = out_weight_r;
  assign out_last           = out_last_r;

endmodule

// File: src/sndsyn_checker.sv
// Port-level assertions for the spiking neuron top level, with its bind.
module sndsyn_checker #(
  parameter int TARGET_BITS = 8
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_spike,
  input logic [15:0]            out_membrane,
  input logic                   out_deliver_valid,
  input logic [TARGET_BITS-1:0] out_deliver_target,
  input logic signed [15:0]     out_deliver_weight,
  input logic                   out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_membrane) && $stable(out_last)
      && $stable(out_deliver_valid) && $stable(out_deliver_target)
      && $stable(out_deliver_weight) && $stable(out_spike))
    else $error("result transaction changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous transaction in progress");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_deliver_valid |-> out_deliver_target == '0 && out_deliver_weight == '0)
    else $error("status result carries delivery fields");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind spiking_neuron_with_delay_synapses sndsyn_checker #(
  .TARGET_BITS (TARGET_BITS)
) u_sndsyn_checker (.*);

// File: verif/tb.sv
// Self-checking testbench for the spiking neuron with delayed synapses.
`timescale 1ns / 1ps

module tb;
  import sndsyn_pkg::*;

  localparam int SYN_N = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [1:0] CMD_NOP = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] input_weight;
    logic [2:0]  synapse_index;
    logic [7:0]  target_index;
    logic [15:0] synapse_weight;
    logic [7:0]  synapse_delay;
  } neuron_cmd_t;

  typedef struct packed {
    logic        spike;
    logic [15:0] membrane;
    logic        deliver_valid;
    logic [7:0]  deliver_target;
    logic [15:0] deliver_weight;
    logic        last;
  } neuron_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_command = CMD_TICK;
  logic signed [15:0]  in_input_weight = '0;
  logic [2:0]          in_synapse_index = '0;
  logic [7:0]          in_target_index = '0;
  logic signed [15:0]  in_synapse_weight = '0;
  logic [7:0]          in_synapse_delay = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_spike;
  logic [15:0]         out_membrane;
  logic                out_deliver_valid;
  logic [7:0]          out_deliver_target;
  logic signed [15:0]  out_deliver_weight;
  logic                out_last;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // predictor state and register copies
  logic [15:0] thr_cfg = 16'd27500;
  logic [11:0] leak_cfg = 12'd100;
  logic [15:0] refr_cfg = 16'd0;
  logic        gen_cfg = 1'b0;
  logic [3:0]  act_cfg = 4'd0;
  int          membrane_v = int'(V_REST);
  int          refr_left = 0;
  int          busy_cnt = 0;
  logic [7:0]  syn_tgt[SYN_N];
  logic [15:0] syn_wt[SYN_N];
  logic [7:0]  syn_dly[SYN_N];
  timer_t      syn_tmr[SYN_N];

  neuron_cmd_t pending_cmds[$];
  neuron_res_t neuron_results_q[$];
  neuron_cmd_t cur_cmd;

  int gap_left = 0;
  int burst_left = 0;
  int items_done = 0;
  int spikes_seen = 0;
  int results_seen = 0;
  int deliveries_seen = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;
  logic [31:0] rx_cycle = '0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;

  spiking_neuron_with_delay_synapses dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_input_weight    (in_input_weight),
    .in_synapse_index   (in_synapse_index),
    .in_target_index    (in_target_index),
    .in_synapse_weight  (in_synapse_weight),
    .in_synapse_delay   (in_synapse_delay),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_spike          (out_spike),
    .out_membrane       (out_membrane),
    .out_deliver_valid  (out_deliver_valid),
    .out_deliver_target (out_deliver_target),
    .out_deliver_weight (out_deliver_weight),
    .out_last           (out_last),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void neuron_step(input neuron_cmd_t c);
    neuron_res_t step_res[$];
    neuron_res_t r;
    int n;
    int v;
    logic spk;
    r = '0;
    if (c.command == CMD_TICK) begin
      n = (act_cfg > SYN_N) ? SYN_N : int'(act_cfg);
      spk = gen_cfg;
      if (membrane_v >= int'(thr_cfg) && refr_left == 0) begin
        membrane_v = int'(V_RESET);
        spk = 1'b1;
        refr_left = int'(refr_cfg);
      end
      if (membrane_v < int'(LEAK_LOW)) begin
        membrane_v = membrane_v + int'(leak_cfg);
        if (membrane_v > 65535) membrane_v = 65535;
      end
      if (membrane_v > int'(LEAK_HIGH)) begin
        membrane_v = (membrane_v > int'(leak_cfg)) ? membrane_v - int'(leak_cfg) : 0;
      end
      if (refr_left > 0) refr_left--;
      if (spk) spikes_seen++;
      r.spike = spk;
      r.membrane = membrane_v[15:0];
      step_res.push_back(r);
      if (spk) begin
        for (int i = 0; i < n; i++) begin
          if (syn_tmr[i] == TIMER_IDLE) begin
            syn_tmr[i] = {1'b0, syn_dly[i]};
            busy_cnt++;
          end
        end
      end
      if (busy_cnt > 0) begin
        for (int i = 0; i < n; i++) begin
          if (syn_tmr[i] == '0) begin
            r.deliver_valid = 1'b1;
            r.deliver_target = syn_tgt[i];
            r.deliver_weight = syn_wt[i];
            step_res.push_back(r);
            if (busy_cnt > 0) busy_cnt--;
            syn_tmr[i] = TIMER_IDLE;
          end else if (syn_tmr[i] != TIMER_IDLE) begin
            syn_tmr[i] = syn_tmr[i] - 1'b1;
          end
        end
      end
    end else begin
      if (c.command == CMD_RECV) begin
        v = membrane_v + int'($signed(c.input_weight));
        if (v < int'(V_RESET)) v = int'(V_RESET);
        if (v > int'(CLAMP_HIGH)) v = int'(CLAMP_HIGH);
        membrane_v = v;
      end else if (c.command == CMD_WRITE) begin
        syn_tgt[c.synapse_index] = c.target_index;
        syn_wt[c.synapse_index] = c.synapse_weight;
        syn_dly[c.synapse_index] = c.synapse_delay;
      end
      r.membrane = membrane_v[15:0];
      step_res.push_back(r);
    end
    step_res[step_res.size()-1].last = 1'b1;
    foreach (step_res[k]) neuron_results_q.push_back(step_res[k]);
  endfunction

  function automatic neuron_cmd_t make_cmd(input logic [1:0] cmd, input logic [15:0] iw,
                                           input logic [2:0] idx, input logic [7:0] tgt,
                                           input logic [15:0] sw, input logic [7:0] dly);
    neuron_cmd_t c;
    c.command = cmd;
    c.input_weight = iw;
    c.synapse_index = idx;
    c.target_index = tgt;
    c.synapse_weight = sw;
    c.synapse_delay = dly;
    return c;
  endfunction

  function automatic neuron_cmd_t random_cmd();
    neuron_cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    c.command = (pick < 55) ? CMD_TICK : (pick < 80) ? CMD_RECV :
                (pick < 95) ? CMD_WRITE : CMD_NOP;
    c.input_weight = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                     16'($signed($urandom_range(0, 24000)) - 12000);
    c.synapse_index = 3'($urandom);
    c.target_index = 8'($urandom);
    c.synapse_weight = 16'($urandom);
    c.synapse_delay = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    return c;
  endfunction

  // sender: bursts of transactions separated by random gaps
  always @(posedge clk) begin : sender
    logic nv;
    nv = in_valid;
    if (!rst_n) begin
      nv = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        neuron_step(cur_cmd);
        items_done++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_cmds.size() != 0) begin
          cur_cmd = pending_cmds.pop_front();
          in_command <= cur_cmd.command;
          in_input_weight <= cur_cmd.input_weight;
          in_synapse_index <= cur_cmd.synapse_index;
          in_target_index <= cur_cmd.target_index;
          in_synapse_weight <= cur_cmd.synapse_weight;
          in_synapse_delay <= cur_cmd.synapse_delay;
          nv = 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 9))
              0, 1, 2, 3: gap_left = 0;
              4, 5, 6, 7: gap_left = $urandom_range(1, 4);
              8: gap_left = $urandom_range(5, 15);
              default: gap_left = $urandom_range(20, 40);
            endcase
          end
        end
      end
    end
    in_valid <= nv;
  end

  always @(posedge clk) begin : long_hold
    if (hold_go && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver: check each result, stall on a rotating pattern
  always @(posedge clk) begin : receiver
    neuron_res_t want;
    logic rdy;
    rx_cycle <= rx_cycle + 1;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (neuron_results_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("MISMATCH: result with none expected: spike %0b membrane %0d dv %0b",
                   out_spike, out_membrane, out_deliver_valid);
      end else begin
        want = neuron_results_q.pop_front();
        if (want.deliver_valid) deliveries_seen++;
        if (out_spike !== want.spike || out_membrane !== want.membrane ||
            out_deliver_valid !== want.deliver_valid ||
            out_deliver_target !== want.deliver_target ||
            out_deliver_weight !== want.deliver_weight || out_last !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("MISMATCH: exp spk %0b mem %0d dv %0b tgt %0d wt %0d last %0b",
                     want.spike, want.membrane, want.deliver_valid, want.deliver_target,
                     $signed(want.deliver_weight), want.last);
            $display("          got spk %0b mem %0d dv %0b tgt %0d wt %0d last %0b",
                     out_spike, out_membrane, out_deliver_valid, out_deliver_target,
                     out_deliver_weight, out_last);
          end
        end
      end
    end
    case (rx_cycle[9:8])
      2'd0: rdy = 1'b1;
      2'd1: rdy = 1'($urandom_range(0, 1));
      2'd2: rdy = (rx_cycle[2:0] != 3'd0);
      default: rdy = ($urandom_range(0, 3) == 0);
    endcase
    out_ready <= rdy && (hold_left == 0);
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || neuron_results_q.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_V_THRESHOLD:      thr_cfg = val[15:0];
      REG_LEAK_STEP:        leak_cfg = val[11:0];
      REG_REFRACTORY_TICKS: refr_cfg = val[15:0];
      REG_IS_GENERATOR:     gen_cfg = val[0];
      REG_ACTIVE_SYNAPSES:  act_cfg = val[3:0];
      default: ;
    endcase
  endtask

  task automatic program_neuron(input int thr, input int leak, input int refr,
                                input int gen, input int act);
    wait_drained();
    reg_write(REG_V_THRESHOLD, 32'(thr));
    reg_write(REG_LEAK_STEP, 32'(leak));
    reg_write(REG_REFRACTORY_TICKS, 32'(refr));
    reg_write(REG_IS_GENERATOR, 32'(gen));
    reg_write(REG_ACTIVE_SYNAPSES, 32'(act));
  endtask

  task automatic queue_random(input int n);
    repeat (n) pending_cmds.push_back(random_cmd());
  endtask

  initial begin
    for (int i = 0; i < SYN_N; i++) begin
      syn_tgt[i] = '0;
      syn_wt[i] = '0;
      syn_dly[i] = '0;
      syn_tmr[i] = TIMER_IDLE;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // load every synapse entry while none is in use
    program_neuron(27500, 100, 0, 0, 0);
    pending_cmds.push_back(make_cmd(CMD_WRITE, 16'h0000, 3'd0, 8'd0,   16'h7FFF, 8'd0));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 16'hFFFF, 3'd1, 8'd255, 16'h8000, 8'd1));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 16'h5555, 3'd2, 8'hAA,  16'h1234, 8'd2));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 16'hAAAA, 3'd3, 8'h55,  16'hFFFF, 8'd3));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 16'h0001, 3'd4, 8'd1,   16'd100,  8'd0));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 16'h8000, 3'd5, 8'd128, 16'hFF38, 8'd255));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 16'h7FFF, 3'd6, 8'd7,   16'd5000, 8'd1));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 16'h0000, 3'd7, 8'd254, 16'h0000, 8'd0));
    pending_cmds.push_back(make_cmd(CMD_RECV,  16'h7FFF, 3'd7, 8'hFF,  16'hFFFF, 8'hFF));
    pending_cmds.push_back(make_cmd(CMD_TICK,  16'h0000, 3'd0, 8'd0,   16'h0000, 8'd0));
    pending_cmds.push_back(make_cmd(CMD_RECV,  16'h8000, 3'd0, 8'd0,   16'h0000, 8'd0));
    pending_cmds.push_back(make_cmd(CMD_NOP,   16'hFFFF, 3'd7, 8'hFF,  16'hFFFF, 8'hFF));
    pending_cmds.push_back(make_cmd(CMD_TICK,  16'hFFFF, 3'd7, 8'hFF,  16'hFFFF, 8'hFF));

    // generator mode with all entries active
    program_neuron(27500, 100, 0, 1, 8);
    repeat (5) pending_cmds.push_back(make_cmd(CMD_TICK, '0, '0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_WRITE, 16'h0000, 3'd6, 8'd77, 16'h0042, 8'd0));
    repeat (5) pending_cmds.push_back(make_cmd(CMD_TICK, '0, '0, '0, '0, '0));

    program_neuron($urandom_range(20000, 30000), $urandom_range(0, 600),
                   $urandom_range(0, 5), 0, 8);
    queue_random(60);

    // extreme settings, active count above the table size
    program_neuron(0, 4095, 65535, 1, 15);
    queue_random(50);

    // shrink the active range while timers are still running
    program_neuron(65535, 0, 3, 0, 4);
    queue_random(36);

    program_neuron($urandom_range(18000, 52000), $urandom_range(0, 4095),
                   $urandom_range(0, 20), $urandom_range(0, 1), $urandom_range(0, 15));
    hold_go <= 1'b1;
    queue_random(80);

    program_neuron(28000, 1, 1, 1, 8);
    queue_random(70);

    program_neuron($urandom_range(0, 65535), $urandom_range(0, 4095),
                   $urandom_range(0, 8), $urandom_range(0, 1), $urandom_range(0, 15));
    queue_random(50);

    wait_drained();
    repeat (20) @(negedge clk);
    mismatch_cnt += neuron_results_q.size();
    $display("Covered %0d transactions over 8 register settings, %0d of them spiking ticks.",
             items_done, spikes_seen);
    $display("Checked %0d results, %0d of them synapse deliveries.",
             results_seen, deliveries_seen);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
